FILE: rtl/core/sstf_pkg.sv
// Shared types and codes for the SSTF request scheduler.
// No dependencies; imported by the scheduler top level.
`default_nettype none

package sstf_pkg;

	// pending_count port width, count is reported modulo 2**PCOUNT_BITS
	localparam int PCOUNT_BITS = 6;

	typedef enum logic [1:0] {
		STAT_ADDED  = 2'd0,
		STAT_SERVED = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	localparam logic MODE_ADD      = 1'b0;
	localparam logic MODE_DISPATCH = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_SHIFT,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/sstf_nearest.sv
// Nearest-sector tracker: seek gap per scanned slot, keeps the closest one.
// Stand-alone; fed by the slot memory read port of the scheduler top level.
`default_nettype none

module sstf_nearest #(
	parameter int SECTOR_BITS = 48,
	parameter int TAG_BITS    = 8,
	parameter int IDX_BITS    = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clear,
	input  logic                   entry_valid,
	input  logic [IDX_BITS-1:0]    entry_idx,
	input  logic [SECTOR_BITS-1:0] entry_sector,
	input  logic                   entry_write,
	input  logic [TAG_BITS-1:0]    entry_tag,
	input  logic [SECTOR_BITS-1:0] head,
	output logic                   busy,
	output logic [IDX_BITS-1:0]    best_idx,
	output logic [SECTOR_BITS-1:0] best_sector,
	output logic                   best_write,
	output logic [TAG_BITS-1:0]    best_tag
);

	logic [SECTOR_BITS:0]   diff_fwd;
	logic [SECTOR_BITS-1:0] diff_rev;
	logic [SECTOR_BITS-1:0] gap;

	logic                   vld_s2;
	logic [SECTOR_BITS-1:0] gap_s2;
	logic [IDX_BITS-1:0]    idx_s2;
	logic [SECTOR_BITS-1:0] sector_s2;
	logic                   write_s2;
	logic [TAG_BITS-1:0]    tag_s2;

	logic                   have_q;
	logic [SECTOR_BITS-1:0] best_gap_q;
	logic [IDX_BITS-1:0]    best_idx_q;
	logic [SECTOR_BITS-1:0] best_sector_q;
	logic                   best_write_q;
	logic [TAG_BITS-1:0]    best_tag_q;
	logic                   take;

	// |head - sector|: borrow of the forward difference picks the direction
	assign diff_fwd = {1'b0, head} - {1'b0, entry_sector};
	assign diff_rev = entry_sector - head;
	assign gap      = diff_fwd[SECTOR_BITS] ? diff_rev : diff_fwd[SECTOR_BITS-1:0];

	// strict less-than: slots arrive in queue order, so ties keep the oldest
	assign take = vld_s2 && (!have_q || (gap_s2 < best_gap_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			have_q <= 1'b0;
		end else begin
			vld_s2 <= entry_valid && !clear;
			if (clear) begin
				have_q <= 1'b0;
			end else if (take) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (entry_valid) begin
			gap_s2    <= gap;
			idx_s2    <= entry_idx;
			sector_s2 <= entry_sector;
			write_s2  <= entry_write;
			tag_s2    <= entry_tag;
		end
		if (take) begin
			best_gap_q    <= gap_s2;
			best_idx_q    <= idx_s2;
			best_sector_q <= sector_s2;
			best_write_q  <= write_s2;
			best_tag_q    <= tag_s2;
		end
	end

	assign busy        = vld_s2;
	assign best_idx    = best_idx_q;
	assign best_sector = best_sector_q;
	assign best_write  = best_write_q;
	assign best_tag    = best_tag_q;

endmodule

`default_nettype wire

FILE: rtl/core/sstf_request_scheduler.sv
// SSTF scheduler top: slot memory, control sequencer, output word register.
// Uses sstf_pkg and sstf_nearest.
// Flow: an add, a rejected add or an empty dispatch goes straight to the result
//   state; a dispatch over pending requests scans every slot, drains the compare
//   pipe, closes up the slots behind the winner and then loads its result. One
//   word in flight; the next word is accepted in the cycle after the result loads.
//   The slot memory takes one read and one write per cycle during close-up.
// Reset: arst_n clears queue count, head position and handshake state; the
//   slot memory is not cleared, only slots below the count are ever read.
`default_nettype none

module sstf_request_scheduler #(
	parameter int QUEUE_DEPTH = 32,
	parameter int SECTOR_BITS = 48,
	parameter int TAG_BITS    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request side
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic [SECTOR_BITS-1:0]            request_sector,
	input  logic                              request_is_write,
	input  logic [TAG_BITS-1:0]               request_tag,
	// result side
	output logic                              out_valid,
	input  logic                              out_stall,
	output sstf_pkg::status_t                 status,
	output logic [SECTOR_BITS-1:0]            served_sector,
	output logic                              served_is_write,
	output logic [TAG_BITS-1:0]               served_tag,
	output logic [sstf_pkg::PCOUNT_BITS-1:0]  pending_count
);

	import sstf_pkg::*;

	// AW addresses a slot, CW holds a count 0..QUEUE_DEPTH
	localparam int AW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int PCW = (CW > PCOUNT_BITS) ? CW : PCOUNT_BITS;

	typedef struct packed {
		logic [SECTOR_BITS-1:0] sector;
		logic                   write;
		logic [TAG_BITS-1:0]    tag;
	} entry_t;

	// slot memory, kept in arrival order
	entry_t mem [QUEUE_DEPTH];

	state_t                 state_q, state_next;
	logic [CW-1:0]          count_q;
	logic [SECTOR_BITS-1:0] head_q;
	logic [CW-1:0]          rd_idx_q;
	status_t                res_status_q;

	// read pipeline
	logic                   rd_vld_s1;
	logic [CW-1:0]          rd_idx_s1;
	entry_t                 rd_data_s1;

	// output word register
	logic                   out_valid_q;
	status_t                status_q;
	logic [SECTOR_BITS-1:0] served_sector_q;
	logic                   served_write_q;
	logic [TAG_BITS-1:0]    served_tag_q;
	logic [PCOUNT_BITS-1:0] pending_q;

	logic                   accept;
	logic                   room;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	entry_t                 wr_data;
	logic [CW-1:0]          shift_dst;
	logic                   shift_done;
	logic                   out_load;
	logic                   clear_best;
	logic [PCW-1:0]         count_ext;

	logic                   near_busy;
	logic [CW-1:0]          best_idx;
	logic [SECTOR_BITS-1:0] best_sector;
	logic                   best_write;
	logic [TAG_BITS-1:0]    best_tag;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign room     = (count_q < CW'(QUEUE_DEPTH));

	// ---------------- next state ----------------
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((mode == MODE_DISPATCH) && (count_q != '0)) begin
						state_next = S_SCAN;
					end else begin
						state_next = S_RESULT;
					end
				end
			end
			S_SCAN: begin
				// all slots issued, let the compare pipe empty
				if (rd_idx_q == count_q) begin
					state_next = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!rd_vld_s1 && !near_busy) begin
					state_next = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (shift_done) begin
					state_next = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	// ---------------- datapath controls ----------------
	always_comb begin
		rd_en      = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = count_q[AW-1:0];
		wr_data    = '{sector: request_sector, write: request_is_write, tag: request_tag};
		shift_dst  = rd_idx_s1 - CW'(1);
		shift_done = 1'b0;
		out_load   = 1'b0;
		clear_best = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// append at the tail in the accept cycle
				wr_en      = accept && (mode == MODE_ADD) && room;
				clear_best = accept;
			end
			S_SCAN: begin
				rd_en = (rd_idx_q != count_q);
			end
			S_DRAIN: begin
			end
			S_SHIFT: begin
				// close up: slot j+1 is read, and written to slot j in the following cycle
				rd_en      = (rd_idx_q != count_q);
				wr_en      = rd_vld_s1;
				wr_addr    = shift_dst[AW-1:0];
				wr_data    = rd_data_s1;
				shift_done = (rd_idx_q == count_q) && !rd_vld_s1;
			end
			S_RESULT: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = rd_idx_q[AW-1:0];

	// ---------------- slot memory ----------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			res_status_q <= STAT_ADDED;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_next;
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_s1 <= rd_idx_q;
			end

			if (accept) begin
				rd_idx_q <= '0;
				if (mode == MODE_ADD) begin
					res_status_q <= room ? STAT_ADDED : STAT_FULL;
					if (room) begin
						count_q <= count_q + CW'(1);
					end
				end else begin
					res_status_q <= (count_q != '0) ? STAT_SERVED : STAT_EMPTY;
				end
			end else if ((state_q == S_DRAIN) && (state_next == S_SHIFT)) begin
				// close-up starts at the slot behind the winner
				rd_idx_q <= best_idx + CW'(1);
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end

			if (shift_done) begin
				count_q <= count_q - CW'(1);
				head_q  <= best_sector;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- output word ----------------
	assign count_ext = PCW'(count_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q  <= res_status_q;
			pending_q <= count_ext[PCOUNT_BITS-1:0];
			if (res_status_q == STAT_SERVED) begin
				served_sector_q <= best_sector;
				served_write_q  <= best_write;
				served_tag_q    <= best_tag;
			end else begin
				served_sector_q <= '0;
				served_write_q  <= 1'b0;
				served_tag_q    <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign served_sector   = served_sector_q;
	assign served_is_write = served_write_q;
	assign served_tag      = served_tag_q;
	assign pending_count   = pending_q;

	// ---------------- nearest-sector tracker ----------------
	sstf_nearest #(
		.SECTOR_BITS (SECTOR_BITS),
		.TAG_BITS    (TAG_BITS),
		.IDX_BITS    (CW)
	) u_nearest (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (clear_best),
		.entry_valid  (rd_vld_s1 && (state_q != S_SHIFT)),
		.entry_idx    (rd_idx_s1),
		.entry_sector (rd_data_s1.sector),
		.entry_write  (rd_data_s1.write),
		.entry_tag    (rd_data_s1.tag),
		.head         (head_q),
		.busy         (near_busy),
		.best_idx     (best_idx),
		.best_sector  (best_sector),
		.best_write   (best_write),
		.best_tag     (best_tag)
	);

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_IDLE) || (state_q == S_SHIFT))
		else $error("slot write outside add or close-up");

	a_word_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESULT))
		else $error("output word loaded outside result state");

	a_dispatch_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		shift_done |=> count_q == $past(count_q) - CW'(1))
		else $error("dispatch did not remove exactly one slot");

endmodule

`default_nettype wire
